>>> design/wpmr_pkg.sv
// Package: shared types, codes and helper functions for the word pool match ranker.
`timescale 1ns / 1ps
`default_nettype none
package wpmr_pkg;

   localparam int WORD_BYTES = 16;
   localparam int LEN_W      = 5;
   localparam int CNT_W      = 16;
   localparam int TOT_W      = 17;
   localparam int RANK_W     = 7;
   localparam int KEY_W      = 1 + TOT_W + 8 * WORD_BYTES + LEN_W;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_CHECK  = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [63:0]      word_lo;
      logic [63:0]      word_hi;
      logic [LEN_W-1:0] word_len;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [63:0]       out_word_lo;
      logic [63:0]       out_word_hi;
      logic [LEN_W-1:0]  out_word_len;
      logic [CNT_W-1:0]  correct_count;
      logic [CNT_W-1:0]  typo_count;
      logic [TOT_W-1:0]  total_count;
      logic              last;
   } rsp_type;

   // one pool entry held in a cell
   typedef struct packed {
      logic             valid;
      logic [127:0]     word;     // char i in bits 8i+7..8i
      logic [LEN_W-1:0] len;
      logic [CNT_W-1:0] correct;
      logic [CNT_W-1:0] typo;
   } entry_type;

   // text word travelling down the chain
   typedef struct packed {
      logic             valid;
      logic [127:0]     word;
      logic [LEN_W-1:0] len;
   } token_type;

   typedef struct packed {
      logic clear;
      logic write;
      logic sort;
      logic phase;
      logic shift;
   } cell_ctrl_type;

   // lower-case and zero bytes at or beyond len
   function automatic logic [127:0] normalize(input logic [127:0] w, input logic [LEN_W-1:0] len);
      logic [127:0] r;
      logic [7:0]   c;
      r = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         c = w[8*i +: 8];
         if (c >= 8'h41 && c <= 8'h5A) begin
            c = c + 8'h20;
         end
         if (LEN_W'(i) < len) begin
            r[8*i +: 8] = c;
         end
      end
      return r;
   endfunction

   function automatic logic [TOT_W-1:0] total_of(input entry_type e);
      return TOT_W'(e.correct) + TOT_W'(e.typo);
   endfunction

   // larger key ranks earlier: valid, total, then smaller word, then shorter
   function automatic logic [KEY_W-1:0] rank_key(input entry_type e);
      logic [127:0] rv;
      for (int i = 0; i < WORD_BYTES; i++) begin
         rv[127 - 8*i -: 8] = ~e.word[8*i +: 8];
      end
      return {e.valid, total_of(e), rv, ~e.len};
   endfunction

endpackage
`default_nettype wire

>>> design/wpmr_cell.sv
// One chain cell: holds a pool entry, scores passing text words, sorts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module wpmr_cell
   import wpmr_pkg::*;
#(
   parameter logic ODD_POS = 1'b0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          wr_sel,
   input  wire entry_type     wr_data,
   input  wire token_type     tok_i,
   input  wire entry_type     left_ent,
   input  wire logic          left_swap,
   input  wire entry_type     right_ent,
   output entry_type          ent_o,
   output token_type          tok_o,
   output logic               swap_o
);

   entry_type ent_ff, ent_in;
   token_type tok_ff;
   logic [LEN_W-1:0] match_cnt;

   assign ent_o  = ent_ff;
   assign tok_o  = tok_ff;
   assign swap_o = rank_key(right_ent) > rank_key(ent_ff);

   always_comb begin
      match_cnt = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (LEN_W'(i) < tok_i.len && tok_i.word[8*i +: 8] == ent_ff.word[8*i +: 8]) begin
            match_cnt = match_cnt + LEN_W'(1);
         end
      end
   end

   always_comb begin
      ent_in = ent_ff;
      if (ctrl.clear) begin
         ent_in.valid = 1'b0;
      end else if (ctrl.write && wr_sel) begin
         ent_in = wr_data;
      end else if (ctrl.shift) begin
         ent_in = right_ent;
      end else if (ctrl.sort) begin
         if (ctrl.phase == ODD_POS) begin
            if (swap_o) begin
               ent_in = right_ent;
            end
         end else if (left_swap) begin
            ent_in = left_ent;
         end
      end else if (tok_i.valid && ent_ff.valid && tok_i.len == ent_ff.len) begin
         if (match_cnt == tok_i.len) begin
            if (ent_ff.correct != CNT_MAX) begin
               ent_in.correct = ent_ff.correct + CNT_W'(1);
            end
         end else if (match_cnt >= (tok_i.len >> 1)) begin
            if (ent_ff.typo != CNT_MAX) begin
               ent_in.typo = ent_ff.typo + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
         tok_ff.valid <= tok_i.valid;
      end
      ent_ff.word    <= ent_in.word;
      ent_ff.len     <= ent_in.len;
      ent_ff.correct <= ent_in.correct;
      ent_ff.typo    <= ent_in.typo;
      tok_ff.word    <= tok_i.word;
      tok_ff.len     <= tok_i.len;
   end

endmodule
`default_nettype wire

>>> design/word_pool_match_ranker.sv
// Top level: word pool match ranker built as a chain of entry cells.
//
// Input channel req_*: one item per handshake (valid high, stall low).
//   mode 0 adds a pool word, mode 1 checks a text word, mode 2 finishes.
// Result channel rsp_*: on finish, one item per pool entry in rank order,
//   highest total first, ties by word in ascending byte order; last marks
//   the final one. An empty pool gives no items.
// An add item writes the next free cell. A check item enters the token register and
//   walks one cell per cycle down the chain of POOL_WORDS cells, so checks
//   may follow each other every cycle; a finish is held off until the last
//   token has left the chain.
// Finish: odd-even neighbor sorting in the cells, then the chain shifts
//   toward cell 0 once per result taken; the first result shows in the
//   cycle after the last sort pass, later ones every cycle unless stalled.
// Input is stalled while sorting and emitting.
// Receiver stall holds cell 0 and the whole chain, so results stay put.
// Reset empties the pool, clears the check flag and returns to idle.
`timescale 1ns / 1ps
`default_nettype none
module word_pool_match_ranker
   import wpmr_pkg::*;
#(
   parameter int POOL_WORDS   = 64,
   parameter int MAX_WORD_LEN = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int SZ_W = $clog2(POOL_WORDS + 1);
   localparam int DR_W = $clog2(POOL_WORDS + 2);

   state_type        state_ff, state_in;
   logic [SZ_W-1:0]  size_ff, size_in;
   logic [SZ_W-1:0]  pass_ff, pass_in;
   logic [DR_W-1:0]  drain_ff, drain_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic             checking_ff, checking_in;
   token_type        tok0_ff, tok0_in;
   cell_ctrl_type    ctrl;

   logic             req_acc, rsp_acc;
   logic [LEN_W-1:0] len_clamp;
   logic [127:0]     norm_word;
   entry_type        wr_data;

   entry_type ent_x  [0:POOL_WORDS+1];
   token_type tok_x  [0:POOL_WORDS];
   logic      swap_x [0:POOL_WORDS];

   // clamp overlong words, then lower-case and pad with zeros
   assign len_clamp = (req_data.word_len > LEN_W'(MAX_WORD_LEN)) ?
                      LEN_W'(MAX_WORD_LEN) : req_data.word_len;
   assign norm_word = normalize({req_data.word_hi, req_data.word_lo}, len_clamp);

   always_comb begin
      wr_data         = '0;
      wr_data.valid   = 1'b1;
      wr_data.word    = norm_word;
      wr_data.len     = len_clamp;
   end

   assign req_stall = (state_ff != ST_IDLE) ||
                      (req_data.mode == MODE_FINISH && drain_ff != '0);
   assign req_acc   = req_valid && !req_stall;

   // result comes straight from cell 0
   assign rsp_valid = (state_ff == ST_EMIT) && ent_x[1].valid;
   assign rsp_acc   = rsp_valid && !rsp_stall;

   always_comb begin
      rsp_data               = '0;
      rsp_data.rank          = rank_ff;
      rsp_data.out_word_lo   = ent_x[1].word[63:0];
      rsp_data.out_word_hi   = ent_x[1].word[127:64];
      rsp_data.out_word_len  = ent_x[1].len;
      rsp_data.correct_count = ent_x[1].correct;
      rsp_data.typo_count    = ent_x[1].typo;
      rsp_data.total_count   = total_of(ent_x[1]);
      rsp_data.last          = !ent_x[2].valid;
   end

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      pass_in     = pass_ff;
      rank_in     = rank_ff;
      checking_in = checking_ff;
      drain_in    = (drain_ff != '0) ? drain_ff - DR_W'(1) : drain_ff;
      tok0_in       = '0;
      tok0_in.word  = norm_word;
      tok0_in.len   = len_clamp;
      ctrl        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_data.mode)
                  MODE_ADD: begin
                     if (len_clamp != '0 && !checking_ff && size_ff < SZ_W'(POOL_WORDS)) begin
                        ctrl.write = 1'b1;
                        size_in    = size_ff + SZ_W'(1);
                     end
                  end
                  MODE_CHECK: begin
                     if (len_clamp != '0) begin
                        checking_in   = 1'b1;
                        tok0_in.valid = 1'b1;
                        drain_in      = DR_W'(POOL_WORDS + 1);
                     end
                  end
                  MODE_FINISH: begin
                     state_in = ST_SORT;
                     pass_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SORT: begin
            ctrl.sort  = 1'b1;
            ctrl.phase = pass_ff[0];
            pass_in    = pass_ff + SZ_W'(1);
            if (pass_ff == SZ_W'(POOL_WORDS - 1)) begin
               state_in = ST_EMIT;
               rank_in  = RANK_W'(1);
            end
         end
         ST_EMIT: begin
            if (!ent_x[1].valid) begin
               ctrl.clear  = 1'b1;
               size_in     = '0;
               checking_in = 1'b0;
               state_in    = ST_IDLE;
            end else if (rsp_acc) begin
               ctrl.shift = 1'b1;
               rank_in    = rank_ff + RANK_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         size_ff       <= '0;
         pass_ff       <= '0;
         drain_ff      <= '0;
         rank_ff       <= RANK_W'(1);
         checking_ff   <= 1'b0;
         tok0_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         pass_ff       <= pass_in;
         drain_ff      <= drain_in;
         rank_ff       <= rank_in;
         checking_ff   <= checking_in;
         tok0_ff.valid <= tok0_in.valid;
      end
      tok0_ff.word <= tok0_in.word;
      tok0_ff.len  <= tok0_in.len;
   end

   // chain ends: empty neighbors
   assign ent_x[0]              = '0;
   assign ent_x[POOL_WORDS + 1] = '0;
   assign swap_x[0]             = 1'b0;
   assign tok_x[0]              = tok0_ff;

   for (genvar i = 0; i < POOL_WORDS; i++) begin : g_cell
      wpmr_cell #(
         .ODD_POS (1'(i % 2))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .wr_sel    (size_ff == SZ_W'(i)),
         .wr_data   (wr_data),
         .tok_i     (tok_x[i]),
         .left_ent  (ent_x[i]),
         .left_swap (swap_x[i]),
         .right_ent (ent_x[i + 2]),
         .ent_o     (ent_x[i + 1]),
         .tok_o     (tok_x[i + 1]),
         .swap_o    (swap_x[i + 1])
      );
   end

endmodule
`default_nettype wire

>>> design/wpmr_checker.sv
// Port-level checker for the word pool match ranker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wpmr_checker
   import wpmr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=>
         rsp_valid && rsp_data.rank == RANK_W'($past(rsp_data.rank) + RANK_W'(1)))
      else $error("ranking not contiguous");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid)
      else $error("result after last");

   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.total_count ==
         TOT_W'(rsp_data.correct_count) + TOT_W'(rsp_data.typo_count))
      else $error("total mismatch");

   a_no_input_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(req_valid && !req_stall))
      else $error("input taken during ranking output");

endmodule

bind word_pool_match_ranker wpmr_checker u_wpmr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> tb/word_pool_match_ranker_test.sv
// Testbench for the word pool match ranker: directed and random pools checked against a predictor.
`timescale 1ns / 1ps
module word_pool_match_ranker_test;
   import wpmr_pkg::*;

   localparam int POOL_DEPTH = 64;
   localparam int WORD_MAX   = 16;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   word_pool_match_ranker uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor state: the pool as the block should hold it
   logic [127:0]     pool_word [POOL_DEPTH];
   logic [LEN_W-1:0] pool_len  [POOL_DEPTH];
   logic [CNT_W-1:0] pool_hits [POOL_DEPTH];
   logic [CNT_W-1:0] pool_typos[POOL_DEPTH];
   int               pool_count;
   logic             checks_begun;

   rsp_type ranking_queue[$];   // expected ranking items, oldest first
   int      error_count;
   int      send_idle_pct;      // sender idle chance, percent
   int      recv_idle_pct;      // receiver idle chance, percent
   int      hold_off_cycles;    // long receiver hold-off, counted below

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [127:0] got,
                                  input logic [127:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [127:0] fold_case(input logic [127:0] w, input int len);
      logic [127:0] r;
      logic [7:0]   c;
      r = '0;
      for (int i = 0; i < len; i++) begin
         c = w[8*i +: 8];
         if (c >= "A" && c <= "Z") c = c + 8'd32;
         r[8*i +: 8] = c;
      end
      return r;
   endfunction

   // true when pool entry a goes ahead of entry b in the ranking
   function automatic bit ranks_ahead(input int a, input int b);
      int ta, tb, n;
      ta = pool_hits[a] + pool_typos[a];
      tb = pool_hits[b] + pool_typos[b];
      if (ta != tb) return ta > tb;
      n = pool_len[a] < pool_len[b] ? pool_len[a] : pool_len[b];
      for (int i = 0; i < n; i++)
         if (pool_word[a][8*i +: 8] != pool_word[b][8*i +: 8])
            return pool_word[a][8*i +: 8] < pool_word[b][8*i +: 8];
      return pool_len[a] < pool_len[b];
   endfunction

   // apply one accepted item to the predicted pool
   task automatic predict_item(input req_type it);
      int           len, m, k, j, cur;
      logic [127:0] w;
      int           order[POOL_DEPTH];
      rsp_type      r;
      len = it.word_len > WORD_MAX ? WORD_MAX : it.word_len;
      w   = fold_case({it.word_hi, it.word_lo}, len);
      case (it.mode)
         MODE_ADD: begin
            if (len != 0 && !checks_begun && pool_count < POOL_DEPTH) begin
               pool_word[pool_count]  = w;
               pool_len[pool_count]   = LEN_W'(len);
               pool_hits[pool_count]  = '0;
               pool_typos[pool_count] = '0;
               pool_count++;
            end
         end
         MODE_CHECK: begin
            if (len != 0) begin
               checks_begun = 1'b1;
               for (int e = 0; e < pool_count; e++) begin
                  if (pool_len[e] == len) begin
                     m = 0;
                     for (int i = 0; i < len; i++)
                        if (w[8*i +: 8] == pool_word[e][8*i +: 8]) m++;
                     if (m == len) begin
                        if (pool_hits[e] != CNT_MAX) pool_hits[e]++;
                     end else if (m >= len / 2) begin
                        if (pool_typos[e] != CNT_MAX) pool_typos[e]++;
                     end
                  end
               end
            end
         end
         MODE_FINISH: begin
            for (k = 0; k < pool_count; k++) order[k] = k;
            for (k = 1; k < pool_count; k++) begin
               cur = order[k];
               j = k;
               while (j > 0 && ranks_ahead(cur, order[j-1])) begin
                  order[j] = order[j-1];
                  j--;
               end
               order[j] = cur;
            end
            for (k = 0; k < pool_count; k++) begin
               r.rank          = RANK_W'(k + 1);
               r.out_word_lo   = pool_word[order[k]][63:0];
               r.out_word_hi   = pool_word[order[k]][127:64];
               r.out_word_len  = pool_len[order[k]];
               r.correct_count = pool_hits[order[k]];
               r.typo_count    = pool_typos[order[k]];
               r.total_count   = TOT_W'(pool_hits[order[k]]) + TOT_W'(pool_typos[order[k]]);
               r.last          = (k + 1 == pool_count);
               ranking_queue   = {ranking_queue, r};
            end
            pool_count   = 0;
            checks_begun = 1'b0;
         end
         default: ;
      endcase
   endtask

   // send one item; it is predicted at the edge that accepts it
   // entered and left at a falling edge; valid stays up until the next call idles
   task automatic send_item(input logic [1:0] mode, input logic [127:0] w, input int len);
      req_type it;
      it.mode     = mode;
      it.word_lo  = w[63:0];
      it.word_hi  = w[127:64];
      it.word_len = LEN_W'(len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(it);
      @(negedge clock);
   endtask

   task automatic drain_ranking();
      req_valid <= 1'b0;
      @(negedge clock);
      while (ranking_queue.size() != 0) @(negedge clock);
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ranking_queue.size() == 0) begin
            report_mismatch("unexpected item", {rsp_data.out_word_hi, rsp_data.out_word_lo},
                            '0);
         end else begin
            want = ranking_queue.pop_front();
            if (rsp_data.rank != want.rank)
               report_mismatch("rank", 128'(rsp_data.rank), 128'(want.rank));
            if (rsp_data.out_word_lo != want.out_word_lo)
               report_mismatch("word_lo", 128'(rsp_data.out_word_lo), 128'(want.out_word_lo));
            if (rsp_data.out_word_hi != want.out_word_hi)
               report_mismatch("word_hi", 128'(rsp_data.out_word_hi), 128'(want.out_word_hi));
            if (rsp_data.out_word_len != want.out_word_len)
               report_mismatch("len", 128'(rsp_data.out_word_len), 128'(want.out_word_len));
            if (rsp_data.correct_count != want.correct_count)
               report_mismatch("correct", 128'(rsp_data.correct_count),
                               128'(want.correct_count));
            if (rsp_data.typo_count != want.typo_count)
               report_mismatch("typo", 128'(rsp_data.typo_count), 128'(want.typo_count));
            if (rsp_data.total_count != want.total_count)
               report_mismatch("total", 128'(rsp_data.total_count), 128'(want.total_count));
            if (rsp_data.last != want.last)
               report_mismatch("last", 128'(rsp_data.last), 128'(want.last));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // random word; letters in both cases mostly, any byte now and then and past len
   function automatic logic [127:0] random_word(input int len);
      logic [127:0] w;
      for (int i = 0; i < 16; i++) begin
         if (i >= len || $urandom_range(9) == 0) w[8*i +: 8] = 8'($urandom);
         else w[8*i +: 8] = ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(3));
      end
      return w;
   endfunction

   // copy of a word with some positions changed (typo or miss)
   function automatic logic [127:0] garble(input logic [127:0] w, input int len);
      int n;
      n = $urandom_range(len);
      for (int i = 0; i < n; i++) w[8*$urandom_range(len-1) +: 8] = "z";
      return w;
   endfunction

   task automatic test_directed();
      logic [127:0] ones;
      ones = {16{8'hFF}};
      // empty pool finish: nothing comes out
      send_item(MODE_FINISH, '0, 0);
      send_item(MODE_ADD, {"PONMLKJIHGFEDCBA"}, 16);
      send_item(MODE_ADD, ones, 31);                 // overlong, taken as 16
      send_item(MODE_ADD, {120'h0, "x"}, 0);         // zero length, ignored
      send_item(MODE_ADD, {120'h0, "Q"}, 1);
      send_item(MODE_ADD, {112'h0, "qz"}, 2);
      send_item(MODE_ADD, {112'h0, "qz"}, 2);        // duplicate
      send_item(MODE_ADD, {96'h0, "cab"}, 3);
      send_item(2'd3, ones, 5);                       // unknown mode
      send_item(MODE_CHECK, {"ponmlkjihgfedcba"}, 16);
      send_item(MODE_CHECK, {"ponmlkjihZZZZZZZ"}, 16);
      send_item(MODE_CHECK, {120'h0, "q"}, 1);
      send_item(MODE_CHECK, {112'h0, "ZZ"}, 2);      // one match, len/2 = 1: typo
      send_item(MODE_CHECK, {112'h0, "Za"}, 2);
      send_item(MODE_CHECK, ones, 0);                 // zero length, ignored
      send_item(MODE_ADD, {96'h0, "aaa"}, 3);        // after checking: ignored
      send_item(MODE_CHECK, ones, 16);
      send_item(MODE_FINISH, ones, 7);
      drain_ranking();
   endtask

   // fill the pool beyond its depth, then rank it while the receiver holds off
   task automatic test_full_pool_hold_off();
      for (int i = 0; i < POOL_DEPTH + 3; i++)
         send_item(MODE_ADD, random_word(4), $urandom_range(1, 4));
      send_item(MODE_CHECK, random_word(3), 3);
      hold_off_cycles = 400;
      send_item(MODE_FINISH, '0, 0);
      send_item(MODE_ADD, random_word(2), 2);        // queued behind the ranking
      send_item(MODE_FINISH, '0, 0);
      drain_ranking();
   endtask

   // one entry hit by a run of exact checks, another by a run of typos
   task automatic test_repeated_checks();
      send_item(MODE_ADD, {120'h0, "k"}, 1);
      send_item(MODE_ADD, {112'h0, "kk"}, 2);
      for (int i = 0; i < 12; i++)
         send_item(MODE_CHECK, {120'h0, "K"}, 1);
      for (int i = 0; i < 12; i++)
         send_item(MODE_CHECK, {112'h0, "zk"}, 2);
      send_item(MODE_FINISH, '0, 0);
      drain_ranking();
   endtask

   // well-formed rounds of adds, checks, finish with random content and noise
   task automatic test_random_rounds(input int items);
      int           sent, len, n;
      logic [127:0] w;
      logic [127:0] added[$];
      int           added_len[$];
      sent = 0;
      while (sent < items) begin
         added.delete();
         added_len.delete();
         n = $urandom_range(9) == 0 ? $urandom_range(40, 66) : $urandom_range(1, 10);
         for (int i = 0; i < n; i++) begin
            len = $urandom_range(7) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5);
            w = random_word(len);
            added     = {added, w};
            added_len = {added_len, (len > 16 ? 16 : (len == 0 ? 1 : len))};
            send_item($urandom_range(19) == 0 ? 2'($urandom_range(1, 3)) : MODE_ADD, w, len);
            sent++;
         end
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) != 0 && added.size() != 0) begin
               int k;
               k = $urandom_range(added.size() - 1);
               w = $urandom_range(1) ? added[k] : garble(added[k], added_len[k]);
               send_item(MODE_CHECK, w, added_len[k]);
            end else begin
               send_item(2'($urandom_range(3)), random_word(16), $urandom_range(0, 31));
            end
            sent++;
         end
         send_item(MODE_FINISH, random_word(16), $urandom_range(0, 31));
         sent++;
      end
      drain_ranking();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      rsp_stall       = 1'b0;
      hold_off_cycles = 0;
      error_count     = 0;
      pool_count      = 0;
      checks_begun    = 1'b0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 51;
      test_directed();
      test_full_pool_hold_off();
      test_random_rounds(60);
      send_idle_pct = 51;
      recv_idle_pct = 7;
      test_random_rounds(60);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_repeated_checks();
      test_random_rounds(60);

      // idle while no item is expected, so any unexpected trailing item is caught
      for (int i = 0; i < 400 && ranking_queue.size() == 0; i++) @(negedge clock);
      if (error_count == 0 && ranking_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

>>> files.f
design/wpmr_pkg.sv
design/wpmr_cell.sv
design/word_pool_match_ranker.sv
design/wpmr_checker.sv
tb/word_pool_match_ranker_test.sv
